FILE: rtl/ndr_pkg.sv
// Package for the nearest delta R search block.
// Holds the transaction structs, sequencer states and fixed-point constants.
// Depends on nothing; the top level and the checker use it by scoped names.
`default_nettype none

package ndr_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic signed [17:0] FX_PI     = 18'sd12868;
	localparam logic signed [17:0] FX_TWO_PI = 18'sd25736;
	localparam logic [15:0]        DIST_MAX  = 16'hFFFF;

	// Root bits produced for a 34-bit radicand, one per cycle.
	localparam int ROOT_STEPS = 17;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] eta;
		logic signed [15:0] phi;
		logic [5:0]         slot;
		logic [6:0]         entry_count;
	} req_t;

	typedef struct packed {
		logic [15:0] distance;
		logic [5:0]  nearest_slot;
		logic        found;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIFF,
		ST_SQ_ETA,
		ST_SQ_PHI,
		ST_CMP,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/nearest_delta_r_search.sv
// Top level of the nearest delta R search: object store, shared squaring unit,
// compare sequencer and bit-serial square root. Uses ndr_pkg and ndr_ram.
//
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | ndr_pkg::req_t (load or query)
// rsp     | out       | rsp_valid, rsp_stall | ndr_pkg::rsp_t (one per query)
//
// A query runs over the first n store entries (n is the saturated count, the skipped
// entry included) and goes straight to the result register when n is 0. After ST_FETCH,
// each entry passes through ST_DIFF, ST_SQ_ETA, ST_SQ_PHI and ST_CMP because one
// multiplier squares both differences, and the root then yields one result bit per cycle.
// req_stall is high while a query runs and while its result waits for the output
// register to free up. A finished result waits in the output register while new
// loads and queries are taken. Reset clears the sequencer and the result valid;
// the store is not cleared.
`default_nettype none

module nearest_delta_r_search #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire ndr_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output ndr_pkg::rsp_t       rsp
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int XW = (CW > 6) ? CW : 6;
	localparam int NW = (CW > 7) ? CW : 7;

	ndr_pkg::state_t state_q, state_d;

	logic               req_accept;
	logic               ram_we;
	logic               mul_phi_sel;
	logic               ld_out;
	logic [31:0]        ram_rdata;

	logic signed [15:0] eta_q, phi_q;
	logic [5:0]         skip_q;
	logic [CW-1:0]      cnt_q, idx_q, cur_q, best_idx_q;
	logic [CW-1:0]      cnt_sat;
	logic               skip_ent_q, have_q;
	logic signed [17:0] de_q, dp_q;
	logic [31:0]        sqe_q, sqp_q;
	logic [32:0]        best_q;
	logic [33:0]        rad_q;
	logic [19:0]        rem_q;
	logic [16:0]        root_q;
	logic [4:0]         step_q;
	logic               rsp_valid_q;
	ndr_pkg::rsp_t      rsp_q, rsp_d;

	logic signed [15:0] eta_i, phi_i;
	logic signed [17:0] de_w, dp_raw, dp_abs, dp_fold;
	logic signed [17:0] mul_op;
	logic signed [35:0] prod;
	logic [32:0]        sum;
	logic               upd;
	logic [32:0]        best_new;
	logic [21:0]        rem_in, trial;

	assign req_accept = req_valid && !req_stall;
	assign req_stall  = (state_q != ndr_pkg::ST_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign cnt_sat = (NW'(req.entry_count) > NW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
		: CW'(req.entry_count);

	ndr_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(AW'(req.slot)),
		.wr_data({req.eta, req.phi}),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(ram_rdata)
	);

	assign eta_i   = ram_rdata[31:16];
	assign phi_i   = ram_rdata[15:0];
	assign de_w    = 18'(eta_q) - 18'(eta_i);
	assign dp_raw  = 18'(phi_q) - 18'(phi_i);
	assign dp_abs  = dp_raw[17] ? -dp_raw : dp_raw;
	assign dp_fold = (dp_abs > ndr_pkg::FX_PI) ? (ndr_pkg::FX_TWO_PI - dp_abs) : dp_abs;

	assign mul_op = mul_phi_sel ? dp_q : de_q;
	assign prod   = mul_op * mul_op;

	assign sum      = {1'b0, sqe_q} + {1'b0, sqp_q};
	assign upd      = !skip_ent_q && (!have_q || (sum < best_q));
	assign best_new = upd ? sum : best_q;

	assign rem_in = {rem_q, rad_q[33:32]};
	assign trial  = {3'b000, root_q, 2'b01};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ndr_pkg::ST_IDLE: begin
				if (req_accept && req.operation == ndr_pkg::OP_QUERY) begin
					state_d = (req.entry_count == 7'd0) ? ndr_pkg::ST_DONE
						: ndr_pkg::ST_FETCH;
				end
			end
			ndr_pkg::ST_FETCH:  state_d = ndr_pkg::ST_DIFF;
			ndr_pkg::ST_DIFF:   state_d = ndr_pkg::ST_SQ_ETA;
			ndr_pkg::ST_SQ_ETA: state_d = ndr_pkg::ST_SQ_PHI;
			ndr_pkg::ST_SQ_PHI: state_d = ndr_pkg::ST_CMP;
			ndr_pkg::ST_CMP: begin
				state_d = (idx_q == cnt_q) ? ndr_pkg::ST_ROOT : ndr_pkg::ST_DIFF;
			end
			ndr_pkg::ST_ROOT: begin
				if (step_q == 5'd0) begin
					state_d = ndr_pkg::ST_DONE;
				end
			end
			ndr_pkg::ST_DONE: begin
				if (ld_out) begin
					state_d = ndr_pkg::ST_IDLE;
				end
			end
			default: state_d = ndr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we      = 1'b0;
		mul_phi_sel = 1'b0;
		ld_out      = 1'b0;
		unique case (state_q)
			ndr_pkg::ST_IDLE: begin
				ram_we = req_accept && (req.operation == ndr_pkg::OP_LOAD)
					&& (XW'(req.slot) < XW'(MAX_ENTRIES));
			end
			ndr_pkg::ST_SQ_PHI: mul_phi_sel = 1'b1;
			ndr_pkg::ST_DONE:   ld_out = !rsp_valid_q || !rsp_stall;
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp_d.found = have_q;
		if (have_q) begin
			rsp_d.distance     = root_q[16] ? ndr_pkg::DIST_MAX : root_q[15:0];
			rsp_d.nearest_slot = 6'(best_idx_q);
		end else begin
			rsp_d.distance     = ndr_pkg::DIST_MAX;
			rsp_d.nearest_slot = 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ndr_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			rsp_q <= rsp_d;
		end
		unique case (state_q)
			ndr_pkg::ST_IDLE: begin
				if (req_accept) begin
					eta_q  <= req.eta;
					phi_q  <= req.phi;
					skip_q <= req.slot;
					cnt_q  <= cnt_sat;
					idx_q  <= '0;
					have_q <= 1'b0;
				end
			end
			ndr_pkg::ST_DIFF: begin
				de_q       <= de_w;
				dp_q       <= dp_fold;
				cur_q      <= idx_q;
				skip_ent_q <= (XW'(idx_q) == XW'(skip_q));
				idx_q      <= idx_q + 1'b1;
			end
			ndr_pkg::ST_SQ_ETA: sqe_q <= prod[31:0];
			ndr_pkg::ST_SQ_PHI: sqp_q <= prod[31:0];
			ndr_pkg::ST_CMP: begin
				if (upd) begin
					have_q     <= 1'b1;
					best_q     <= sum;
					best_idx_q <= cur_q;
				end
				rad_q  <= {1'b0, best_new};
				rem_q  <= '0;
				root_q <= '0;
				step_q <= 5'(ndr_pkg::ROOT_STEPS - 1);
			end
			ndr_pkg::ST_ROOT: begin
				rad_q  <= {rad_q[31:0], 2'b00};
				step_q <= step_q - 1'b1;
				if (rem_in >= trial) begin
					rem_q  <= 20'(rem_in - trial);
					root_q <= {root_q[15:0], 1'b1};
				end else begin
					rem_q  <= rem_in[19:0];
					root_q <= {root_q[15:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/ndr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters; no package dependency.
`default_nettype none

module ndr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/ndr_checker.sv
// Port-level checker for the nearest delta R search, bound to the top level.
// Uses ndr_pkg for the transaction types and constants.
`default_nettype none

module ndr_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire ndr_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire ndr_pkg::rsp_t rsp
);

	// A result that is not taken holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// A running query keeps the request side stalled in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.operation == ndr_pkg::OP_QUERY |=> req_stall)
		else $error("request taken during a query");

	// No result appears in the cycle after any accepted transaction.
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(rsp_valid))
		else $error("result appeared too early");

	// An empty search reports saturated distance and slot zero.
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.distance == ndr_pkg::DIST_MAX
			&& rsp.nearest_slot == 6'd0)
		else $error("empty result not saturated");

endmodule

bind nearest_delta_r_search ndr_checker u_ndr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

`default_nettype wire
